FILE: rtl/u8mc_pkg.sv
package u8mc_pkg;

	// Width of the saturating byte counter
	localparam int COUNT_BITS = 21;
	// Width of the length limit register
	localparam int LEN_BITS = 21;
	// Width used for the length compare
	localparam int CMP_BITS = (COUNT_BITS > LEN_BITS) ? COUNT_BITS : LEN_BITS;
	// Width of an assembled code point
	localparam int CP_BITS = 21;

	localparam logic [LEN_BITS-1:0]   MAX_LENGTH_RESET = LEN_BITS'(1048576);
	localparam logic [COUNT_BITS-1:0] COUNT_CAP        = '1;

	localparam logic [CP_BITS-1:0] CP_MIN_3BYTE = CP_BITS'(32'h0000_0800);
	localparam logic [CP_BITS-1:0] CP_MIN_4BYTE = CP_BITS'(32'h0001_0000);
	localparam logic [CP_BITS-1:0] CP_MAX       = CP_BITS'(32'h0010_FFFF);
	localparam logic [CP_BITS-1:0] CP_SURR_LO   = CP_BITS'(32'h0000_D800);
	localparam logic [CP_BITS-1:0] CP_SURR_HI   = CP_BITS'(32'h0000_DFFF);

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_TOO_LONG = 2'd1,
		STATUS_BAD_UTF8 = 2'd2,
		STATUS_HAS_ZERO = 2'd3
	} status_t;

endpackage

FILE: rtl/u8mc_if.sv
interface u8mc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface u8mc_status_if;
	logic              valid;
	logic              ready;
	u8mc_pkg::status_t status;

	modport source (output valid, output status, input ready);
	modport sink   (input valid, input status, output ready);
endinterface

interface u8mc_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [u8mc_pkg::LEN_BITS-1:0] max_length;

	modport source (output valid, output max_length, input ready);
	modport sink   (input valid, input max_length, output ready);
endinterface

FILE: rtl/utf8_message_checker.sv
// A last byte passes through the input stage and then the result register before its status shows on result.
// Throughput: one byte per cycle; the input stage holds only while a status waits on result.
// The per-byte decode is one pass of logic between the input stage and the state registers.
// Reset (arst_n low, asynchronous): empty pipeline, message state cleared,
// max_length back to 1048576.
module utf8_message_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	u8mc_byte_if.sink            msg,
	u8mc_status_if.source        result,
	u8mc_cfg_if.sink             cfg
);

	// Input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Length limit
	logic [u8mc_pkg::LEN_BITS-1:0] max_len_q;

	// Message state
	logic [1:0]                      exp_q;
	logic [1:0]                      seq_q;
	logic [u8mc_pkg::CP_BITS-1:0]    cv_q;
	logic                            err_q;
	logic                            zero_q;
	logic [u8mc_pkg::COUNT_BITS-1:0] cnt_q;

	// Next message state
	logic [1:0]                      exp_n;
	logic [1:0]                      seq_n;
	logic [u8mc_pkg::CP_BITS-1:0]    cv_n;
	logic [u8mc_pkg::CP_BITS-1:0]    cv_shift;
	logic                            err_n;
	logic                            zero_n;
	logic [u8mc_pkg::COUNT_BITS-1:0] cnt_n;
	u8mc_pkg::status_t               status_n;

	// Result register
	logic              out_valid_q;
	u8mc_pkg::status_t status_q;

	logic out_free;
	logic s1_go;

	// The result register can take a new status when empty or being drained.
	assign out_free = !out_valid_q || result.ready;
	// Advance the input stage; only a last byte needs room in the result register.
	assign s1_go    = valid_s1 && (!last_s1 || out_free);
	assign msg.ready = !valid_s1 || s1_go;

	assign result.valid  = out_valid_q;
	assign result.status = status_q;

	// Configuration writes are always taken.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= u8mc_pkg::MAX_LENGTH_RESET;
		end else if (cfg.valid) begin
			max_len_q <= cfg.max_length;
		end
	end

	// Input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (msg.ready) begin
			valid_s1 <= msg.valid;
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (msg.valid && msg.ready) begin
			byte_s1 <= msg.data_byte;
			last_s1 <= msg.last_byte;
		end
	end

	// Decode one byte against the current message state.
	always_comb begin
		exp_n    = exp_q;
		seq_n    = seq_q;
		cv_n     = cv_q;
		err_n    = err_q;
		cv_shift = {cv_q[u8mc_pkg::CP_BITS-7:0], byte_s1[5:0]};

		// Saturate the byte count.
		cnt_n  = (cnt_q == u8mc_pkg::COUNT_CAP) ? cnt_q : cnt_q + 1'b1;
		zero_n = zero_q || (byte_s1 == 8'h00);

		// Once an error is flagged, stop decoding until the message ends.
		if (!err_q) begin
			if (exp_q != 2'd0) begin
				if (byte_s1[7:6] != 2'b10) begin
					err_n = 1'b1;
				end else begin
					cv_n  = cv_shift;
					exp_n = exp_q - 2'd1;
					// Sequence complete: reject overlong forms, out of range and surrogates.
					if (exp_q == 2'd1) begin
						if ((seq_q == 2'd2 && cv_shift < u8mc_pkg::CP_MIN_3BYTE) ||
						    (seq_q == 2'd3 && cv_shift < u8mc_pkg::CP_MIN_4BYTE) ||
						    (cv_shift > u8mc_pkg::CP_MAX) ||
						    (cv_shift >= u8mc_pkg::CP_SURR_LO &&
						     cv_shift <= u8mc_pkg::CP_SURR_HI)) begin
							err_n = 1'b1;
						end
					end
				end
			end else if (byte_s1 inside {[8'h00:8'h7F]}) begin
				// Plain ASCII: nothing to track
			end else if (byte_s1 inside {[8'hC2:8'hDF]}) begin
				seq_n = 2'd1;
				exp_n = 2'd1;
				cv_n  = u8mc_pkg::CP_BITS'(byte_s1[4:0]);
			end else if (byte_s1 inside {[8'hE0:8'hEF]}) begin
				seq_n = 2'd2;
				exp_n = 2'd2;
				cv_n  = u8mc_pkg::CP_BITS'(byte_s1[3:0]);
			end else if (byte_s1 inside {[8'hF0:8'hF4]}) begin
				seq_n = 2'd3;
				exp_n = 2'd3;
				cv_n  = u8mc_pkg::CP_BITS'(byte_s1[2:0]);
			end else begin
				err_n = 1'b1;
			end
		end

		// Status for a last byte; an open sequence counts as truncated.
		if (u8mc_pkg::CMP_BITS'(cnt_n) > u8mc_pkg::CMP_BITS'(max_len_q)) begin
			status_n = u8mc_pkg::STATUS_TOO_LONG;
		end else if (err_n || (exp_n != 2'd0)) begin
			status_n = u8mc_pkg::STATUS_BAD_UTF8;
		end else if (zero_n) begin
			status_n = u8mc_pkg::STATUS_HAS_ZERO;
		end else begin
			status_n = u8mc_pkg::STATUS_OK;
		end
	end

	// Message state: update on each byte, clear after the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q  <= 2'd0;
			seq_q  <= 2'd0;
			cv_q   <= '0;
			err_q  <= 1'b0;
			zero_q <= 1'b0;
			cnt_q  <= '0;
		end else if (s1_go) begin
			if (last_s1) begin
				exp_q  <= 2'd0;
				seq_q  <= 2'd0;
				cv_q   <= '0;
				err_q  <= 1'b0;
				zero_q <= 1'b0;
				cnt_q  <= '0;
			end else begin
				exp_q  <= exp_n;
				seq_q  <= seq_n;
				cv_q   <= cv_n;
				err_q  <= err_n;
				zero_q <= zero_n;
				cnt_q  <= cnt_n;
			end
		end
	end

	// Result register control: load on a last byte, drop after the transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (s1_go && last_s1) begin
			status_q <= status_n;
		end
	end

endmodule

FILE: rtl/u8mc_checker.sv
module u8mc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              msg_valid,
	input logic              msg_ready,
	input logic              msg_last,
	input logic              res_valid,
	input logic              res_ready,
	input u8mc_pkg::status_t res_status
);

	// Hold a stalled status.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_status))
		else $error("status dropped or changed while stalled");

	// Backpressure on input only comes from a stalled status.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!msg_ready |-> res_valid && !res_ready)
		else $error("input stalled without a stalled status");

	// A fresh status follows a last-byte transfer that went through the input stage and the result register.
	a_res_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(msg_valid && msg_ready && msg_last, 2))
		else $error("status without a last byte");

endmodule

bind utf8_message_checker u8mc_checker u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.msg_valid  (msg.valid),
	.msg_ready  (msg.ready),
	.msg_last   (msg.last_byte),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_status (result.status)
);
